@@ rtl/core/u8u16_pkg.sv @@
// shared types, constants and helper functions for the utf-8 to utf-16 decoder
// no dependencies
package u8u16_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 21;
  localparam int unsigned CAP_W   = 21;
  localparam int unsigned CFG_W   = 21;
  localparam int unsigned IDX_W   = 1;
  localparam int unsigned PEND_W  = 2;

  // default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_UNIT_MODE = 1'b0;
  localparam logic [IDX_W-1:0] REG_CAPACITY  = 1'b1;

  // unit modes
  localparam logic MODE_UTF16 = 1'b0;
  localparam logic MODE_UTF32 = 1'b1;

  localparam logic [CAP_W-1:0]  CAP_RESET   = 21'h100000;
  localparam logic [UNIT_W-1:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [UNIT_W-1:0] POINT_MAX   = 21'h10FFFF;
  localparam logic [UNIT_W-1:0] SUPP_BASE   = 21'h010000;
  localparam logic [UNIT_W-1:0] HI_SURR     = 21'h00D800;
  localparam logic [UNIT_W-1:0] LO_SURR     = 21'h00DC00;
  localparam logic [1:0]        CONT_TAG    = 2'b10;

  // one decoded byte: up to two payload units, or a terminator
  typedef struct packed {
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic              pair;
    logic              is_end;
    logic              ok;
  } job_t;

  // room left once a string starts, capacity zero behaves like one
  function automatic logic [CAP_W-1:0] initial_room(input logic [CAP_W-1:0] cap);
    initial_room = (cap == '0) ? '0 : cap - CAP_W'(1);
  endfunction

  function automatic logic [UNIT_W-1:0] high_surrogate(input logic [UNIT_W-1:0] cp);
    logic [UNIT_W-1:0] off;
    off = cp - SUPP_BASE;
    high_surrogate = (off >> 10) + HI_SURR;
  endfunction

  function automatic logic [UNIT_W-1:0] low_surrogate(input logic [UNIT_W-1:0] cp);
    low_surrogate = {11'd0, cp[9:0]} + LO_SURR;
  endfunction

endpackage

@@ rtl/core/u8u16_front.sv @@
// front end: accepts utf-8 bytes, tracks sequence state and room, builds jobs
// depends on u8u16_pkg
module u8u16_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [u8u16_pkg::IDX_W-1:0]     cfg_index,
  input  logic [u8u16_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            accept,
  input  logic [u8u16_pkg::BYTE_W-1:0]    byte_in,
  output logic                            push,
  output u8u16_pkg::job_t                 job
);

  logic                             mode_r;
  logic [u8u16_pkg::CAP_W-1:0]      cap_r;
  logic [u8u16_pkg::UNIT_W-1:0]     partial_r, partial_nxt;
  logic [u8u16_pkg::PEND_W-1:0]     pend_r, pend_nxt;
  logic                             halted_r, halted_nxt;
  logic [u8u16_pkg::CAP_W-1:0]      room_r, room_nxt;
  logic                             good_r, good_nxt;

  logic [u8u16_pkg::UNIT_W-1:0]     cont_point;
  logic [u8u16_pkg::UNIT_W-1:0]     cp;
  logic                             finish;
  logic                             emit;

  assign cont_point = {partial_r[u8u16_pkg::UNIT_W-7:0], byte_in[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    pend_nxt    = pend_r;
    halted_nxt  = halted_r;
    room_nxt    = room_r;
    good_nxt    = good_r;
    finish      = 1'b0;
    cp          = {13'd0, byte_in};
    emit        = 1'b0;
    job         = '0;

    if (byte_in == '0) begin
      // terminator, then a fresh string
      job.is_end  = 1'b1;
      job.ok      = good_r && (pend_r == '0);
      emit        = 1'b1;
      partial_nxt = '0;
      pend_nxt    = '0;
      halted_nxt  = 1'b0;
      room_nxt    = u8u16_pkg::initial_room(cap_r);
      good_nxt    = 1'b1;
    end else if (halted_r) begin
      emit = 1'b0;
    end else if (pend_r != '0) begin
      if (byte_in[7:6] != u8u16_pkg::CONT_TAG) begin
        good_nxt   = 1'b0;
        halted_nxt = 1'b1;
        pend_nxt   = '0;
      end else begin
        partial_nxt = cont_point;
        pend_nxt    = pend_r - u8u16_pkg::PEND_W'(1);
        cp          = cont_point;
        finish      = (pend_r == u8u16_pkg::PEND_W'(1));
      end
    end else if (byte_in[7] == 1'b0) begin
      finish = 1'b1;
    end else if (byte_in inside {[8'hC0:8'hDF]}) begin
      partial_nxt = {16'd0, byte_in[4:0]};
      pend_nxt    = 2'd1;
    end else if (byte_in inside {[8'hE0:8'hEF]}) begin
      partial_nxt = {17'd0, byte_in[3:0]};
      pend_nxt    = 2'd2;
    end else if (byte_in inside {[8'hF0:8'hF7]}) begin
      partial_nxt = {18'd0, byte_in[2:0]};
      pend_nxt    = 2'd3;
    end else begin
      good_nxt   = 1'b0;
      halted_nxt = 1'b1;
    end

    // completed code point: spend room, then emit
    if (finish) begin
      if (room_r == '0) begin
        halted_nxt = 1'b1;
      end else if (cp <= u8u16_pkg::BMP_MAX) begin
        room_nxt  = room_r - u8u16_pkg::CAP_W'(1);
        job.unit0 = cp;
        emit      = 1'b1;
      end else if (room_r == u8u16_pkg::CAP_W'(1)) begin
        room_nxt   = '0;
        halted_nxt = 1'b1;
      end else begin
        room_nxt = room_r - u8u16_pkg::CAP_W'(2);
        if (cp > u8u16_pkg::POINT_MAX) begin
          good_nxt = 1'b0;
        end else if (mode_r == u8u16_pkg::MODE_UTF16) begin
          job.unit0 = u8u16_pkg::high_surrogate(cp);
          job.unit1 = u8u16_pkg::low_surrogate(cp);
          job.pair  = 1'b1;
          emit      = 1'b1;
        end else begin
          job.unit0 = cp;
          emit      = 1'b1;
        end
      end
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= u8u16_pkg::MODE_UTF16;
      cap_r     <= u8u16_pkg::CAP_RESET;
      partial_r <= '0;
      pend_r    <= '0;
      halted_r  <= 1'b0;
      room_r    <= u8u16_pkg::initial_room(u8u16_pkg::CAP_RESET);
      good_r    <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == u8u16_pkg::REG_UNIT_MODE) begin
        mode_r <= cfg_data[0];
      end else if (cfg_index == u8u16_pkg::REG_CAPACITY) begin
        cap_r  <= cfg_data;
        room_r <= u8u16_pkg::initial_room(cfg_data);
      end
    end else if (accept) begin
      partial_r <= partial_nxt;
      pend_r    <= pend_nxt;
      halted_r  <= halted_nxt;
      room_r    <= room_nxt;
      good_r    <= good_nxt;
    end
  end

endmodule

@@ rtl/core/u8u16_queue.sv @@
// small job queue between front and back, register based
// depends on u8u16_pkg
module u8u16_queue #(
  parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u8u16_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output u8u16_pkg::job_t head_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8u16_pkg::job_t  mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/u8u16_back.sv @@
// back end: turns queued jobs into result beats, two beats for a surrogate pair
// depends on u8u16_pkg
module u8u16_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  u8u16_pkg::job_t               job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8u16_pkg::UNIT_W-1:0]  out_code_unit,
  output logic                          out_is_end,
  output logic                          out_ok,
  output logic                          out_last
);

  logic second_r;
  logic take;

  assign out_valid     = job_valid;
  assign take          = job_valid && !out_stall;
  assign out_code_unit = second_r ? job.unit1 : job.unit0;
  assign out_is_end    = job.is_end;
  assign out_ok        = job.ok;
  assign out_last      = !job.pair || second_r;
  assign pop           = take && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (take) begin
      second_r <= !out_last;
    end
  end

endmodule

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// utf-8 byte stream to utf-16 or utf-32 code unit decoder, top level
// the job built from an accepted byte is registered in the job queue, whose head drives the result port
// throughput: one byte per cycle while the job queue has room; a surrogate pair needs two result
// beats, so sustained rate is set by the result port, one beat per cycle while out_stall is low
// reset: synchronous active-low rst_n; mode utf-16, capacity 1048576, queue empty
// depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back
module utf8_to_utf16_decoder #(
  parameter int unsigned QDEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [u8u16_pkg::IDX_W-1:0]   cfg_index,
  input  logic [u8u16_pkg::CFG_W-1:0]   cfg_data,
  // byte input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [u8u16_pkg::BYTE_W-1:0]  in_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8u16_pkg::UNIT_W-1:0]  out_code_unit,
  output logic                          out_is_end,
  output logic                          out_ok,
  output logic                          out_last
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_not_empty;
  u8u16_pkg::job_t front_job;
  u8u16_pkg::job_t head_job;

  // front stalls only when the job queue has no free slot
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // decode state, room accounting and config registers
  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .byte_in   (in_byte),
    .push      (push),
    .job       (front_job)
  );

  // decouples byte intake from result delivery
  u8u16_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (front_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // one beat per cycle from the queue head while out_stall is low
  u8u16_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_not_empty),
    .job           (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_unit (out_code_unit),
    .out_is_end    (out_is_end),
    .out_ok        (out_ok),
    .out_last      (out_last)
  );

endmodule

@@ test/testbench.sv @@
// testbench for utf8_to_utf16_decoder: byte strings in, code unit beats out, checked
// against a behavioral decoder kept in step with every accepted byte and register write
// depends on u8u16_pkg and the decoder top level only
module testbench;

  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off, fills the job queue
  localparam int SETTLE_CYCLES = 8;     // covers the job queue register plus queue depth, with slack
  localparam int STUCK_LIMIT   = 2000;  // cycles with no beat on any port
  localparam int SEG_BYTES     = 30;
  localparam int SEGMENTS      = 8;
  localparam int PRINT_LIMIT   = 100;

  // one result beat as the decoder presents it
  typedef struct packed {
    logic [u8u16_pkg::UNIT_W-1:0] code_unit;
    logic                         is_end;
    logic                         ok;
    logic                         last;
  } unit_beat_t;

  // opening stimulus row: byte, and a typed expectation where it is obvious
  typedef struct packed {
    logic [u8u16_pkg::BYTE_W-1:0] data;
    logic                         typed;
    unit_beat_t                   want;
  } byte_row_t;

  localparam unit_beat_t NO_BEAT = '0;

  localparam byte_row_t OPENING_BYTES [25] = '{
    '{8'h00, 1'b1, '{21'h000000, 1'b1, 1'b1, 1'b1}},  // empty string right after reset
    '{8'h41, 1'b1, '{21'h000041, 1'b0, 1'b0, 1'b1}},
    '{8'h7F, 1'b1, '{21'h00007F, 1'b0, 1'b0, 1'b1}},  // top of the one-byte range
    '{8'hC2, 1'b0, NO_BEAT},
    '{8'h80, 1'b1, '{21'h000080, 1'b0, 1'b0, 1'b1}},  // bottom of the two-byte range
    '{8'hE0, 1'b0, NO_BEAT},
    '{8'h80, 1'b0, NO_BEAT},
    '{8'h80, 1'b1, '{21'h000000, 1'b0, 1'b0, 1'b1}},  // overlong nul goes through as a unit
    '{8'hF4, 1'b0, NO_BEAT},
    '{8'h8F, 1'b0, NO_BEAT},
    '{8'hBF, 1'b0, NO_BEAT},
    '{8'hBF, 1'b0, NO_BEAT},                          // highest code point, surrogate pair
    '{8'hF7, 1'b0, NO_BEAT},
    '{8'hBF, 1'b0, NO_BEAT},
    '{8'hBF, 1'b0, NO_BEAT},
    '{8'hBF, 1'b0, NO_BEAT},                          // beyond the code space, no beat
    '{8'h00, 1'b1, '{21'h000000, 1'b1, 1'b0, 1'b1}},
    '{8'hFF, 1'b0, NO_BEAT},                          // bad lead byte halts the string
    '{8'h41, 1'b0, NO_BEAT},                          // ignored while halted
    '{8'h00, 1'b1, '{21'h000000, 1'b1, 1'b0, 1'b1}},
    '{8'hC3, 1'b0, NO_BEAT},
    '{8'h41, 1'b0, NO_BEAT},                          // continuation missing
    '{8'h00, 1'b1, '{21'h000000, 1'b1, 1'b0, 1'b1}},
    '{8'hE2, 1'b0, NO_BEAT},
    '{8'h00, 1'b1, '{21'h000000, 1'b1, 1'b0, 1'b1}}   // string cut short by its terminator
  };

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [u8u16_pkg::IDX_W-1:0]       cfg_index;
  logic [u8u16_pkg::CFG_W-1:0]       cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [u8u16_pkg::BYTE_W-1:0]      in_byte;
  logic                              out_valid;
  logic                              out_stall;
  logic [u8u16_pkg::UNIT_W-1:0]      out_code_unit;
  logic                              out_is_end;
  logic                              out_ok;
  logic                              out_last;

  // travel with in_byte, so a typed expectation lands on the right beat
  logic                              in_typed;
  unit_beat_t                        in_want;

  // decoder state as predicted
  logic                              mode_q;
  logic [u8u16_pkg::CAP_W-1:0]       cap_q;
  logic [u8u16_pkg::UNIT_W-1:0]      gathered;
  logic [1:0]                        cont_left;
  logic                              stopped;
  logic [u8u16_pkg::CAP_W-1:0]       room;
  logic                              clean;

  unit_beat_t           new_beats[$];        // beats caused by the byte being decoded
  unit_beat_t           expected_units[$];   // beats still owed by the decoder

  int                   mismatches = 0;
  int                   bytes_sent = 0;
  int                   snd_idle_pct = 14;
  int                   rcv_idle_pct = 68;
  int                   holds_asked = 0;
  int                   holds_done = 0;

  utf8_to_utf16_decoder i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_code_unit(out_code_unit),
    .out_is_end   (out_is_end),
    .out_ok       (out_ok),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: decodes one accepted byte into the beats it should cause
  // ---------------------------------------------------------------------------

  task automatic add_beat(input logic [u8u16_pkg::UNIT_W-1:0] unit, input logic is_end,
                          input logic ok);
    new_beats.push_back('{code_unit: unit, is_end: is_end, ok: ok, last: 1'b0});
  endtask

  // fresh string: room excludes the terminator, capacity zero acts like one
  task automatic restart_string();
    gathered  = '0;
    cont_left = '0;
    stopped   = 1'b0;
    room      = (cap_q == '0) ? '0 : cap_q - 1'b1;
    clean     = 1'b1;
  endtask

  // room is charged before anything is emitted; a supplementary point costs two
  // units in either mode, even when it lies beyond the code space
  task automatic emit_point(input logic [u8u16_pkg::UNIT_W-1:0] cp);
    if (room == '0) begin
      stopped = 1'b1;
    end else begin
      room = room - 1'b1;
      if (cp <= u8u16_pkg::BMP_MAX) begin
        add_beat(cp, 1'b0, 1'b0);
      end else if (room == '0) begin
        stopped = 1'b1;
      end else begin
        room = room - 1'b1;
        if (cp > u8u16_pkg::POINT_MAX) begin
          clean = 1'b0;
        end else if (mode_q == u8u16_pkg::MODE_UTF16) begin
          add_beat(((cp - u8u16_pkg::SUPP_BASE) >> 10) + u8u16_pkg::HI_SURR, 1'b0, 1'b0);
          add_beat({11'd0, cp[9:0]} + u8u16_pkg::LO_SURR, 1'b0, 1'b0);
        end else begin
          add_beat(cp, 1'b0, 1'b0);
        end
      end
    end
  endtask

  task automatic decode_byte(input logic [u8u16_pkg::BYTE_W-1:0] b);
    unit_beat_t tail;
    new_beats.delete();
    if (b == '0) begin
      // terminator always gets out, carrying the string status
      if (cont_left != '0) clean = 1'b0;
      add_beat('0, 1'b1, clean);
      restart_string();
    end else if (stopped) begin
      // halted: nonzero bytes are swallowed
    end else if (cont_left != '0) begin
      if (b[7:6] != u8u16_pkg::CONT_TAG) begin
        clean     = 1'b0;
        stopped   = 1'b1;
        cont_left = '0;
      end else begin
        gathered  = {gathered[u8u16_pkg::UNIT_W-7:0], b[5:0]};
        cont_left = cont_left - 1'b1;
        if (cont_left == '0) emit_point(gathered);
      end
    end else if (!b[7]) begin
      emit_point({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      gathered  = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      gathered  = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      gathered  = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end else begin
      clean   = 1'b0;
      stopped = 1'b1;
    end
    if (new_beats.size() > 0) begin
      tail = new_beats.pop_back();
      tail.last = 1'b1;
      new_beats.push_back(tail);
    end
  endtask

  task automatic apply_write(input logic [u8u16_pkg::IDX_W-1:0] idx,
                             input logic [u8u16_pkg::CFG_W-1:0] val);
    case (idx)
      u8u16_pkg::REG_UNIT_MODE: mode_q = val[0];
      u8u16_pkg::REG_CAPACITY: begin
        cap_q = val;
        room  = (cap_q == '0) ? '0 : cap_q - 1'b1;   // reload takes effect at once
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic check_beat();
    unit_beat_t want;
    if (expected_units.size() == 0) begin
      report_mismatch("beat with nothing outstanding, code_unit", 32'(out_code_unit), 32'd0);
    end else begin
      want = expected_units.pop_front();
      if (out_code_unit !== want.code_unit)
        report_mismatch("code_unit", 32'(out_code_unit), 32'(want.code_unit));
      if (out_is_end !== want.is_end)
        report_mismatch("is_end", 32'(out_is_end), 32'(want.is_end));
      if (out_ok !== want.ok)
        report_mismatch("ok", 32'(out_ok), 32'(want.ok));
      if (out_last !== want.last)
        report_mismatch("last", 32'(out_last), 32'(want.last));
    end
  endtask

  // everything sampled at the rising edge: register writes and bytes feed the
  // predictor, result beats are checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = u8u16_pkg::MODE_UTF16;
      cap_q  = u8u16_pkg::CAP_RESET;
      restart_string();
      expected_units.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        if (in_typed) expected_units.push_back(in_want);
        else foreach (new_beats[k]) expected_units.push_back(new_beats[k]);
      end
      if (out_valid && !out_stall) check_beat();
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one byte, idling cycle by cycle at the current rate, and returns once
  // it is taken
  task automatic send_byte(input logic [u8u16_pkg::BYTE_W-1:0] b, input logic typed,
                           input unit_beat_t want);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_typed <= typed;
    in_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // one zero-terminated string: mostly well-formed sequences with random
  // payload bits, some bad lead bytes and some sequences cut short
  task automatic send_string();
    int                           points;
    int                           kind;
    int                           conts;
    logic [u8u16_pkg::BYTE_W-1:0] lead;
    points = $urandom_range(0, 6);
    for (int p = 0; p < points; p++) begin
      kind  = $urandom_range(0, 99);
      conts = 0;
      if (kind < 30) begin
        lead = 8'($urandom_range(8'h01, 8'h7F));
      end else if (kind < 50) begin
        lead  = 8'($urandom_range(8'hC0, 8'hDF));
        conts = 1;
      end else if (kind < 70) begin
        lead  = 8'($urandom_range(8'hE0, 8'hEF));
        conts = 2;
      end else if (kind < 88) begin
        // mostly inside the code space, now and then beyond it
        if ($urandom_range(0, 9) == 0) lead = 8'($urandom_range(8'hF5, 8'hF7));
        else lead = 8'($urandom_range(8'hF0, 8'hF4));
        conts = 3;
      end else if (kind < 94) begin
        if ($urandom_range(0, 1) == 0) lead = 8'($urandom_range(8'h80, 8'hBF));
        else lead = 8'($urandom_range(8'hF8, 8'hFF));
      end else begin
        // a lead byte, then something other than a continuation
        send_byte(8'($urandom_range(8'hC0, 8'hF7)), 1'b0, NO_BEAT);
        if ($urandom_range(0, 2) == 0) break;   // terminator arrives mid-sequence
        if ($urandom_range(0, 1) == 0) lead = 8'($urandom_range(8'h01, 8'h7F));
        else lead = 8'($urandom_range(8'hC0, 8'hFF));
      end
      send_byte(lead, 1'b0, NO_BEAT);
      repeat (conts) send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0, NO_BEAT);
    end
    send_byte(8'h00, 1'b0, NO_BEAT);
  endtask

  // sender pauses until every owed beat is out, then lets in-flight work settle;
  // the first edge lets the checker record the last accepted byte
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [u8u16_pkg::IDX_W-1:0] idx,
                           input logic [u8u16_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic                        mode;
    logic [u8u16_pkg::CAP_W-1:0] cap;
    int                          start;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= u8u16_pkg::REG_UNIT_MODE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    in_typed  <= 1'b0;
    in_want   <= NO_BEAT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // opening bytes under reset settings: utf-16, full capacity
    for (int r = 0; r < 25; r++)
      send_byte(OPENING_BYTES[r].data, OPENING_BYTES[r].typed, OPENING_BYTES[r].want);

    // random strings, one register setting per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      case (seg)
        0: begin mode = u8u16_pkg::MODE_UTF32; cap = u8u16_pkg::CAP_RESET; end  // largest
        1: begin mode = u8u16_pkg::MODE_UTF16; cap = 21'd1; end   // room for terminator only
        2: begin mode = u8u16_pkg::MODE_UTF32; cap = 21'd3; end
        3: begin mode = u8u16_pkg::MODE_UTF16; cap = 21'd2; end   // a pair never fits
        4: begin mode = u8u16_pkg::MODE_UTF32; cap = '0; end      // zero acts like one
        5: begin mode = u8u16_pkg::MODE_UTF16; cap = 21'($urandom_range(4, 12)); end
        6: begin mode = u8u16_pkg::MODE_UTF32; cap = 21'($urandom_range(3, 8)); end
        default: begin mode = u8u16_pkg::MODE_UTF16; cap = u8u16_pkg::CAP_RESET; end
      endcase
      if (seg < 3) begin
        snd_idle_pct = 14;
        rcv_idle_pct = 68;
      end else if (seg < 6) begin
        snd_idle_pct = 68;
        rcv_idle_pct = 14;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_reg(u8u16_pkg::REG_UNIT_MODE, u8u16_pkg::CFG_W'(mode));
      write_reg(u8u16_pkg::REG_CAPACITY, cap);

      // capacity rewritten with a string half done: room is reloaded at once
      if (seg == 5) begin
        send_byte(8'h41, 1'b0, NO_BEAT);
        send_byte(8'h42, 1'b0, NO_BEAT);
        drain_results();
        write_reg(u8u16_pkg::REG_CAPACITY, 21'($urandom_range(2, 6)));
      end

      // receiver holds off for a long stretch while bytes keep coming
      if (seg == 6) holds_asked++;

      start = bytes_sent;
      while (bytes_sent - start < SEG_BYTES) send_string();
    end

    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus the requested long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // watchdog: too long without a beat on any port ends the run
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_front.sv
rtl/core/u8u16_queue.sv
rtl/core/u8u16_back.sv
rtl/core/utf8_to_utf16_decoder.sv
test/testbench.sv
